// ===== hdl/sobb_pkg.sv =====
package sobb_pkg;

   localparam int WORD_W = 32;
   localparam int DIV_STEPS = 32;
   localparam int PIPE_LAT = DIV_STEPS + 7;
   localparam int CNT_W = $clog2(PIPE_LAT + 1);

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_TEST = 1'b1;

   localparam logic [4:0] WORD_POS = 5'd0;
   localparam logic [4:0] WORD_CTR = 5'd3;
   localparam logic [4:0] WORD_HALF = 5'd6;
   localparam logic [4:0] WORD_ROT = 5'd9;
   localparam logic [4:0] WORD_END = 5'd18;

   localparam logic [1:0] STATUS_NONE = 2'd0;
   localparam logic [1:0] STATUS_FACE = 2'd1;
   localparam logic [1:0] STATUS_INSIDE = 2'd2;

   localparam logic [1:0] FACE_ORDER [3] = '{2'd0, 2'd2, 2'd1};

   localparam logic signed [65:0] WORD_MAX = 66'sd2147483647;
   localparam logic signed [65:0] WORD_MIN = -66'sd2147483648;
   localparam logic signed [31:0] WORD_MOST_NEG = 32'sh80000000;
   localparam logic signed [31:0] WORD_MOST_POS = 32'sh7fffffff;

   typedef struct packed {
      logic              action;
      logic [4:0]        word_index;
      logic signed [31:0] word_value;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] end_z;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] normal_z;
   } rsp_type;

   typedef struct packed {
      logic [2:0][31:0] s;
      logic [2:0][33:0] lo;
      logic [2:0][33:0] hi;
      logic             in_box;
      logic [2:0]       try_lo;
      logic [2:0]       try_hi;
      logic [5:0]       neg;
   } ctx_type;

   typedef struct packed {
      logic [31:0] num;
      logic [31:0] den;
      logic [31:0] u;
      logic [31:0] rem;
      logic [31:0] quo;
   } lane_type;

   function automatic logic signed [31:0] sat_word(input logic signed [65:0] x);
      logic signed [31:0] r;
      if (x > WORD_MAX) r = WORD_MOST_POS;
      else if (x < WORD_MIN) r = WORD_MOST_NEG;
      else r = x[31:0];
      return r;
   endfunction

   function automatic logic signed [31:0] neg_sat(input logic signed [31:0] c);
      logic signed [31:0] r;
      if (c == WORD_MOST_NEG) r = WORD_MOST_POS;
      else r = -c;
      return r;
   endfunction

   function automatic logic [31:0] abs_low(input logic signed [34:0] x);
      logic signed [34:0] m;
      m = (x < 0) ? -x : x;
      return m[31:0];
   endfunction

   function automatic logic [1:0] other_axis(input logic [1:0] a, input logic t);
      logic [1:0] k;
      if (!t) k = (a == 2'd0) ? 2'd1 : 2'd0;
      else k = (a == 2'd2) ? 2'd1 : 2'd2;
      return k;
   endfunction

endpackage

// ===== hdl/segment_obb_entry_point.sv =====
// Channel   Ports                        Beat accepted when
// request   start, busy, req_item        start high and busy low at a clock edge
// response  rsp_strobe, rsp_item         every edge that ends a cycle with rsp_strobe high
//
// One test beat enters per cycle; its response appears once the beat has passed 39 register
// stages: the 32-step restoring divider lanes plus seven arithmetic stages around them.
// A load beat writes the box at once and gives no response.
// Busy is raised only for a load while test beats are still in flight.
// Reset is synchronous and clears the box words, the valid bits and the beat count.
// The response side cannot stall; every stage advances each cycle.
module segment_obb_entry_point #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  sobb_pkg::req_type  req_item,
   output logic               rsp_strobe,
   output sobb_pkg::rsp_type  rsp_item
);

   localparam int NS = sobb_pkg::DIV_STEPS;

   logic signed [31:0] pos_ff [3];
   logic signed [31:0] ctr_ff [3];
   logic signed [31:0] half_ff [3];
   logic signed [31:0] rot_ff [9];

   logic [sobb_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic test_fire, load_fire;
   logic [4:0] off_pos, off_ctr, off_half, off_rot;

   logic va_ff, vb_ff, vc_ff, ve_ff, vf_ff, vg_ff;
   logic vd_ff [NS+1];

   logic signed [31:0] da_ff [6], da_in [6];
   logic signed [63:0] pb_ff [2][3][3], pb_in [2][3][3];
   logic signed [31:0] sc_ff [2][3], sc_in [2][3];
   logic signed [33:0] lo_ff [3], lo_in [3], hi_ff [3], hi_in [3];
   sobb_pkg::ctx_type  ctx_ff [NS+1], ctx_in [1:NS], ctx0_in;
   sobb_pkg::lane_type dv_ff [NS+1][6], dv_in [1:NS][6], dv0_in [6];
   logic [1:0]         ste_ff, ste_in, stf_ff;
   logic signed [31:0] loc_ff [3], loc_in [3];
   logic signed [31:0] nre_ff [3], nre_in [3], nrf_ff [3];
   logic signed [63:0] pf_ff [3][3], pf_in [3][3];
   sobb_pkg::rsp_type  rsp_ff, rsp_in;

   assign test_fire = start && !busy && (req_item.action == sobb_pkg::ACT_TEST);
   assign load_fire = start && !busy && (req_item.action == sobb_pkg::ACT_LOAD);
   assign busy = start && (req_item.action == sobb_pkg::ACT_LOAD) && (cnt_ff != '0);
   assign off_pos = req_item.word_index - sobb_pkg::WORD_POS;
   assign off_ctr = req_item.word_index - sobb_pkg::WORD_CTR;
   assign off_half = req_item.word_index - sobb_pkg::WORD_HALF;
   assign off_rot = req_item.word_index - sobb_pkg::WORD_ROT;

   always_comb begin
      cnt_in = cnt_ff;
      if (test_fire && !vg_ff) cnt_in = cnt_ff + 1'b1;
      else if (!test_fire && vg_ff) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            ctr_ff[i] <= '0;
            half_ff[i] <= '0;
         end
         for (int i = 0; i < 9; i++) rot_ff[i] <= '0;
      end else if (load_fire) begin
         if (req_item.word_index < sobb_pkg::WORD_CTR) begin
            pos_ff[off_pos[1:0]] <= req_item.word_value;
         end else if (req_item.word_index < sobb_pkg::WORD_HALF) begin
            ctr_ff[off_ctr[1:0]] <= req_item.word_value;
         end else if (req_item.word_index < sobb_pkg::WORD_ROT) begin
            half_ff[off_half[1:0]] <= req_item.word_value;
         end else if (req_item.word_index < sobb_pkg::WORD_END) begin
            rot_ff[off_rot[3:0]] <= req_item.word_value;
         end
      end
   end

   always_comb begin
      logic signed [31:0] pt [6];
      pt[0] = req_item.start_x;
      pt[1] = req_item.start_y;
      pt[2] = req_item.start_z;
      pt[3] = req_item.end_x;
      pt[4] = req_item.end_y;
      pt[5] = req_item.end_z;
      for (int n = 0; n < 6; n++) begin
         da_in[n] = sobb_pkg::sat_word(66'(pt[n]) - 66'(pos_ff[n % 3]));
      end
   end

   always_comb begin
      for (int p = 0; p < 2; p++) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               pb_in[p][i][j] = (64'(da_ff[3*p+i]) * 64'(rot_ff[3*i+j])) >>> FRAC_BITS;
            end
         end
      end
   end

   always_comb begin
      for (int p = 0; p < 2; p++) begin
         for (int j = 0; j < 3; j++) begin
            sc_in[p][j] = sobb_pkg::sat_word(66'(pb_ff[p][0][j]) + 66'(pb_ff[p][1][j])
                                             + 66'(pb_ff[p][2][j]));
         end
      end
      for (int i = 0; i < 3; i++) begin
         lo_in[i] = 34'(ctr_ff[i]) - 34'(half_ff[i]);
         hi_in[i] = 34'(ctr_ff[i]) + 34'(half_ff[i]);
      end
   end

   always_comb begin
      logic signed [33:0] sa, ea, plane;
      logic in_box;
      logic [1:0] k;
      ctx0_in = '0;
      in_box = 1'b1;
      for (int a = 0; a < 3; a++) begin
         sa = 34'(sc_ff[0][a]);
         ea = 34'(sc_ff[1][a]);
         ctx0_in.s[a] = sc_ff[0][a];
         ctx0_in.lo[a] = lo_ff[a];
         ctx0_in.hi[a] = hi_ff[a];
         in_box = in_box && (sa > lo_ff[a]) && (sa < hi_ff[a]);
         ctx0_in.try_lo[a] = (sa < lo_ff[a]) && (ea > lo_ff[a]);
         ctx0_in.try_hi[a] = (sa > hi_ff[a]) && (ea < hi_ff[a]);
         plane = ctx0_in.try_lo[a] ? lo_ff[a] : hi_ff[a];
         for (int t = 0; t < 2; t++) begin
            k = sobb_pkg::other_axis(2'(a), t[0]);
            dv0_in[2*a+t].num = sobb_pkg::abs_low(35'(plane) - 35'(sa));
            dv0_in[2*a+t].den = sobb_pkg::abs_low(35'(sa) - 35'(ea));
            dv0_in[2*a+t].u = sobb_pkg::abs_low(35'(sc_ff[1][k]) - 35'(sc_ff[0][k]));
            dv0_in[2*a+t].rem = '0;
            dv0_in[2*a+t].quo = '0;
            ctx0_in.neg[2*a+t] = sc_ff[1][k] < sc_ff[0][k];
         end
      end
      ctx0_in.in_box = in_box;
   end

   always_comb begin
      logic [34:0] r2, d1, d2;
      for (int i = 0; i < NS; i++) begin
         ctx_in[i+1] = ctx_ff[i];
         for (int l = 0; l < 6; l++) begin
            d1 = 35'(dv_ff[i][l].den);
            d2 = d1 << 1;
            r2 = (35'(dv_ff[i][l].rem) << 1)
                 + (dv_ff[i][l].u[31] ? 35'(dv_ff[i][l].num) : 35'd0);
            dv_in[i+1][l] = dv_ff[i][l];
            dv_in[i+1][l].u = dv_ff[i][l].u << 1;
            if (r2 >= d2) begin
               dv_in[i+1][l].rem = 32'(r2 - d2);
               dv_in[i+1][l].quo = (dv_ff[i][l].quo << 1) + 32'd2;
            end else if (r2 >= d1) begin
               dv_in[i+1][l].rem = 32'(r2 - d1);
               dv_in[i+1][l].quo = (dv_ff[i][l].quo << 1) + 32'd1;
            end else begin
               dv_in[i+1][l].rem = 32'(r2);
               dv_in[i+1][l].quo = dv_ff[i][l].quo << 1;
            end
         end
      end
   end

   always_comb begin
      sobb_pkg::ctx_type c;
      logic signed [33:0] cut [3][3];
      logic signed [33:0] q, sk;
      logic hit [3];
      logic found;
      logic [1:0] a, k;
      c = ctx_ff[NS];
      found = 1'b0;
      a = '0;
      for (int x = 0; x < 3; x++) begin
         hit[x] = c.try_lo[x] || c.try_hi[x];
         cut[x][x] = c.try_lo[x] ? $signed(c.lo[x]) : $signed(c.hi[x]);
         for (int t = 0; t < 2; t++) begin
            k = sobb_pkg::other_axis(2'(x), t[0]);
            q = $signed({2'b00, dv_ff[NS][2*x+t].quo});
            sk = 34'($signed(c.s[k]));
            cut[x][k] = c.neg[2*x+t] ? sk - q : sk + q;
            hit[x] = hit[x] && (cut[x][k] > $signed(c.lo[k]))
                     && (cut[x][k] < $signed(c.hi[k]));
         end
      end
      ste_in = sobb_pkg::STATUS_NONE;
      for (int i = 0; i < 3; i++) begin
         loc_in[i] = '0;
         nre_in[i] = '0;
      end
      if (c.in_box) begin
         ste_in = sobb_pkg::STATUS_INSIDE;
         for (int i = 0; i < 3; i++) loc_in[i] = $signed(c.s[i]);
      end else begin
         for (int n = 0; n < 3; n++) begin
            a = sobb_pkg::FACE_ORDER[n];
            if (!found && hit[a]) begin
               found = 1'b1;
               ste_in = sobb_pkg::STATUS_FACE;
               for (int i = 0; i < 3; i++) begin
                  loc_in[i] = cut[a][i][31:0];
                  nre_in[i] = c.try_lo[a] ? sobb_pkg::neg_sat(rot_ff[4'(3*i) + 4'(a)])
                                          : rot_ff[4'(3*i) + 4'(a)];
               end
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pf_in[i][j] = (64'(rot_ff[3*i+j]) * 64'(loc_ff[j])) >>> FRAC_BITS;
         end
      end
   end

   always_comb begin
      logic signed [31:0] w [3];
      for (int i = 0; i < 3; i++) begin
         w[i] = sobb_pkg::sat_word(66'(pos_ff[i]) + 66'(pf_ff[i][0]) + 66'(pf_ff[i][1])
                                   + 66'(pf_ff[i][2]));
      end
      rsp_in.status = stf_ff;
      rsp_in.point_x = (stf_ff == sobb_pkg::STATUS_NONE) ? '0 : w[0];
      rsp_in.point_y = (stf_ff == sobb_pkg::STATUS_NONE) ? '0 : w[1];
      rsp_in.point_z = (stf_ff == sobb_pkg::STATUS_NONE) ? '0 : w[2];
      rsp_in.normal_x = nrf_ff[0];
      rsp_in.normal_y = nrf_ff[1];
      rsp_in.normal_z = nrf_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         for (int i = 0; i <= NS; i++) vd_ff[i] <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
         vg_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         va_ff <= test_fire;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff[0] <= vc_ff;
         for (int i = 0; i < NS; i++) vd_ff[i+1] <= vd_ff[i];
         ve_ff <= vd_ff[NS];
         vf_ff <= ve_ff;
         vg_ff <= vf_ff;
      end
   end

   always_ff @(posedge clock) begin
      da_ff <= da_in;
      pb_ff <= pb_in;
      sc_ff <= sc_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      ctx_ff[0] <= ctx0_in;
      dv_ff[0] <= dv0_in;
      for (int i = 1; i <= NS; i++) begin
         ctx_ff[i] <= ctx_in[i];
         dv_ff[i] <= dv_in[i];
      end
      ste_ff <= ste_in;
      loc_ff <= loc_in;
      nre_ff <= nre_in;
      pf_ff <= pf_in;
      stf_ff <= ste_ff;
      nrf_ff <= nre_ff;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = vg_ff;
   assign rsp_item = rsp_ff;

endmodule

// ===== hdl/sobb_checker.sv =====
module sobb_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input sobb_pkg::req_type req_item,
   input logic              rsp_strobe,
   input sobb_pkg::rsp_type rsp_item
);

   // Only a load beat is ever held off.
   a_busy_load: assert property (@(posedge clock) disable iff (reset)
      busy |-> (start && req_item.action == sobb_pkg::ACT_LOAD))
      else $error("busy raised for a beat that is not a load");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.status == sobb_pkg::STATUS_NONE
                      || rsp_item.status == sobb_pkg::STATUS_FACE
                      || rsp_item.status == sobb_pkg::STATUS_INSIDE))
      else $error("response status out of range");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status == sobb_pkg::STATUS_NONE) |->
      (rsp_item.point_x == 0 && rsp_item.point_y == 0 && rsp_item.point_z == 0
       && rsp_item.normal_x == 0 && rsp_item.normal_y == 0 && rsp_item.normal_z == 0))
      else $error("miss response carries a nonzero point or normal");

   a_inside_normal: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status == sobb_pkg::STATUS_INSIDE) |->
      (rsp_item.normal_x == 0 && rsp_item.normal_y == 0 && rsp_item.normal_z == 0))
      else $error("inside response carries a normal");

endmodule

bind segment_obb_entry_point sobb_checker u_sobb_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .req_item(req_item),
   .rsp_strobe(rsp_strobe),
   .rsp_item(rsp_item)
);

// ===== test/testbench.sv =====
module testbench;

   localparam int FRAC = 16;
   localparam int ONE = 1 << FRAC;
   localparam int LIMIT = 400000;

   class box_scoreboard;
      longint pos[3];
      longint ctr[3];
      longint half[3];
      longint rot[9];
      sobb_pkg::rsp_type hits_due[$];
      int errors;

      function new();
         foreach (pos[i]) begin
            pos[i] = 0;
            ctr[i] = 0;
            half[i] = 0;
         end
         foreach (rot[i]) rot[i] = 0;
         errors = 0;
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      function longint sat(longint x);
         if (x > 64'sd2147483647) return 64'sd2147483647;
         if (x < -64'sd2147483648) return -64'sd2147483648;
         return x;
      endfunction

      function longint qprod(longint a, longint b);
         return (a * b) >>> FRAC;
      endfunction

      function longint mag(longint x);
         return x < 0 ? -x : x;
      endfunction

      function longint scale(longint u, longint num, longint den);
         longint q;
         longint r;
         q = 0;
         r = 0;
         if (den == 0) return 0;
         for (int b = 33; b >= 0; b--) begin
            q = q << 1;
            r = r << 1;
            if ((u >> b) & 1) r += num;
            while (r >= den) begin
               r -= den;
               q++;
            end
         end
         return q;
      endfunction

      function bit face_cut(input longint s[3], input longint e[3], input longint lo[3],
                            input longint hi[3], input int a, input longint plane,
                            output longint cut[3]);
         longint num;
         longint den;
         longint dk;
         longint q;
         num = mag(plane - s[a]);
         den = mag(s[a] - e[a]);
         for (int k = 0; k < 3; k++) begin
            if (k == a) begin
               cut[k] = plane;
            end else begin
               dk = e[k] - s[k];
               q = scale(mag(dk), num, den);
               cut[k] = s[k] + (dk < 0 ? -q : q);
               if (!(cut[k] > lo[k] && cut[k] < hi[k])) return 0;
            end
         end
         return 1;
      endfunction

      function void to_frame(input longint p[3], output longint l[3]);
         longint d[3];
         longint acc;
         for (int i = 0; i < 3; i++) d[i] = sat(p[i] - pos[i]);
         for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int i = 0; i < 3; i++) acc += qprod(d[i], rot[3 * i + j]);
            l[j] = sat(acc);
         end
      endfunction

      function void to_world(input longint l[3], output longint w[3]);
         longint acc;
         for (int i = 0; i < 3; i++) begin
            acc = pos[i];
            for (int j = 0; j < 3; j++) acc += qprod(rot[3 * i + j], l[j]);
            w[i] = sat(acc);
         end
      endfunction

      function void note(sobb_pkg::req_type r);
         longint ps[3];
         longint pe[3];
         longint s[3];
         longint e[3];
         longint lo[3];
         longint hi[3];
         longint cut[3];
         longint w[3];
         longint nrm[3];
         int order[3];
         int a;
         int sign;
         sobb_pkg::rsp_type x;
         if (r.action == sobb_pkg::ACT_LOAD) begin
            if (r.word_index < sobb_pkg::WORD_CTR)
               pos[r.word_index] = r.word_value;
            else if (r.word_index < sobb_pkg::WORD_HALF)
               ctr[r.word_index - sobb_pkg::WORD_CTR] = r.word_value;
            else if (r.word_index < sobb_pkg::WORD_ROT)
               half[r.word_index - sobb_pkg::WORD_HALF] = r.word_value;
            else if (r.word_index < sobb_pkg::WORD_END)
               rot[r.word_index - sobb_pkg::WORD_ROT] = r.word_value;
            return;
         end
         order = '{0, 2, 1};
         ps = '{longint'(r.start_x), longint'(r.start_y), longint'(r.start_z)};
         pe = '{longint'(r.end_x), longint'(r.end_y), longint'(r.end_z)};
         to_frame(ps, s);
         to_frame(pe, e);
         for (int i = 0; i < 3; i++) begin
            lo[i] = ctr[i] - half[i];
            hi[i] = ctr[i] + half[i];
            w[i] = 0;
            nrm[i] = 0;
         end
         x.status = sobb_pkg::STATUS_NONE;
         if (s[0] > lo[0] && s[0] < hi[0] && s[1] > lo[1] && s[1] < hi[1] &&
             s[2] > lo[2] && s[2] < hi[2]) begin
            x.status = sobb_pkg::STATUS_INSIDE;
            to_world(s, w);
         end else begin
            for (int n = 0; n < 3 && x.status == sobb_pkg::STATUS_NONE; n++) begin
               a = order[n];
               sign = 0;
               if (s[a] < lo[a] && e[a] > lo[a] && face_cut(s, e, lo, hi, a, lo[a], cut))
                  sign = -1;
               else if (s[a] > hi[a] && e[a] < hi[a] &&
                        face_cut(s, e, lo, hi, a, hi[a], cut))
                  sign = 1;
               if (sign != 0) begin
                  x.status = sobb_pkg::STATUS_FACE;
                  to_world(cut, w);
                  for (int i = 0; i < 3; i++)
                     nrm[i] = sign < 0 ? sat(-rot[3 * i + a]) : rot[3 * i + a];
               end
            end
         end
         x.point_x = 32'(w[0]);
         x.point_y = 32'(w[1]);
         x.point_z = 32'(w[2]);
         x.normal_x = 32'(nrm[0]);
         x.normal_y = 32'(nrm[1]);
         x.normal_z = 32'(nrm[2]);
         hits_due.push_back(x);
      endfunction

      task field(string name, longint got, longint want);
         if (got != want) report($sformatf("%s got %h expected %h", name, got, want));
      endtask

      task check(sobb_pkg::rsp_type g);
         sobb_pkg::rsp_type w;
         if (hits_due.size() == 0) begin
            report($sformatf("unexpected beat %h", g));
            return;
         end
         w = hits_due.pop_front();
         field("status", g.status, w.status);
         field("point_x", g.point_x, w.point_x);
         field("point_y", g.point_y, w.point_y);
         field("point_z", g.point_z, w.point_z);
         field("normal_x", g.normal_x, w.normal_x);
         field("normal_y", g.normal_y, w.normal_y);
         field("normal_z", g.normal_z, w.normal_z);
      endtask
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   sobb_pkg::req_type req_item;
   logic rsp_strobe;
   sobb_pkg::rsp_type rsp_item;
   box_scoreboard sb;
   int cycles;
   int idle_pct;

   segment_obb_entry_point dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
      if (!reset) begin
         if (rsp_strobe) sb.check(rsp_item);
         if (start && !busy) sb.note(req_item);
      end
   end

   function automatic sobb_pkg::req_type noise_item();
      logic [255:0] raw;
      sobb_pkg::req_type r;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(sobb_pkg::req_type)-1:0];
      return r;
   endfunction

   function automatic sobb_pkg::req_type load_word(logic [4:0] idx, int val);
      sobb_pkg::req_type r;
      r = noise_item();
      r.action = sobb_pkg::ACT_LOAD;
      r.word_index = idx;
      r.word_value = val;
      return r;
   endfunction

   function automatic sobb_pkg::req_type segment(int sx, int sy, int sz,
                                                 int ex, int ey, int ez);
      sobb_pkg::req_type r;
      r = noise_item();
      r.action = sobb_pkg::ACT_TEST;
      r.start_x = sx;
      r.start_y = sy;
      r.start_z = sz;
      r.end_x = ex;
      r.end_y = ey;
      r.end_z = ez;
      return r;
   endfunction

   function automatic int near_coord();
      return int'($urandom_range(0, 24 * ONE)) - 12 * ONE;
   endfunction

   task automatic send(sobb_pkg::req_type r);
      req_item <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if (idle_pct > 0 && int'($urandom_range(0, 99)) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic load_box();
      int rot_kind;
      int perm[3];
      int t;
      int j;
      rot_kind = $urandom_range(0, 3);
      perm = '{0, 1, 2};
      for (int i = 2; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = perm[i];
         perm[i] = perm[j];
         perm[j] = t;
      end
      for (int i = 0; i < 3; i++) begin
         send(load_word(5'(sobb_pkg::WORD_POS + i),
                        int'($urandom_range(0, 8 * ONE)) - 4 * ONE));
         send(load_word(5'(sobb_pkg::WORD_CTR + i),
                        int'($urandom_range(0, 4 * ONE)) - 2 * ONE));
         if ($urandom_range(0, 19) == 0)
            send(load_word(5'(sobb_pkg::WORD_HALF + i), -int'($urandom_range(0, ONE))));
         else
            send(load_word(5'(sobb_pkg::WORD_HALF + i),
                           int'($urandom_range(ONE / 2, 5 * ONE))));
      end
      for (int k = 0; k < 9; k++) begin
         if (rot_kind == 3)
            send(load_word(5'(sobb_pkg::WORD_ROT + k),
                           int'($urandom_range(0, 2 * ONE)) - ONE));
         else if (perm[k / 3] == k % 3)
            send(load_word(5'(sobb_pkg::WORD_ROT + k), $urandom_range(0, 1) ? ONE : -ONE));
         else
            send(load_word(5'(sobb_pkg::WORD_ROT + k), 0));
      end
   endtask

   initial begin
      int pick;
      int phase_pct[4];
      sb = new();
      cycles = 0;
      idle_pct = 0;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(segment(0, 0, 0, ONE, ONE, ONE));
      for (int i = 0; i < 3; i++) begin
         send(load_word(5'(sobb_pkg::WORD_POS + i), (i + 1) * ONE));
         send(load_word(5'(sobb_pkg::WORD_HALF + i), 2 * ONE));
         send(load_word(5'(sobb_pkg::WORD_ROT + 4 * i), ONE));
      end
      send(segment(ONE, 2 * ONE, 3 * ONE, 0, 0, 0));
      send(segment(-5 * ONE, 2 * ONE, 3 * ONE, 5 * ONE, 2 * ONE, 3 * ONE));
      send(segment(7 * ONE, 2 * ONE, 3 * ONE, -5 * ONE, 2 * ONE, 3 * ONE));
      send(segment(ONE, 2 * ONE, -5 * ONE, ONE, 2 * ONE, 9 * ONE));
      send(segment(ONE, 2 * ONE, 9 * ONE, ONE, 2 * ONE, -5 * ONE));
      send(segment(ONE, -5 * ONE, 3 * ONE, ONE, 9 * ONE, 3 * ONE));
      send(segment(ONE, 9 * ONE, 3 * ONE, ONE, -5 * ONE, 3 * ONE));
      send(segment(-9 * ONE, 9 * ONE, 3 * ONE, -8 * ONE, 9 * ONE, 3 * ONE));
      send(segment(9 * ONE, 9 * ONE, 9 * ONE, 9 * ONE, 9 * ONE, 9 * ONE));
      send(segment(32'sh80000000, 32'sh80000000, 32'sh80000000,
                   32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
      send(load_word(5'd20, ONE));
      send(load_word(5'd31, 32'sh80000000));
      send(load_word(5'(sobb_pkg::WORD_HALF + 1), 0));
      send(segment(-5 * ONE, 2 * ONE, 3 * ONE, 5 * ONE, 2 * ONE, 3 * ONE));
      send(load_word(5'(sobb_pkg::WORD_HALF + 1), 2 * ONE));
      send(load_word(sobb_pkg::WORD_ROT, 32'sh80000000));
      send(segment(5 * ONE, 2 * ONE, 3 * ONE, -5 * ONE, 2 * ONE, 3 * ONE));

      phase_pct = '{0, 54, 0, 37};
      foreach (phase_pct[p]) begin
         idle_pct = phase_pct[p];
         load_box();
         for (int n = 0; n < 175; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) load_box();
            else if (pick < 8)
               send(load_word(5'($urandom_range(0, 31)),
                    $urandom_range(0, 1) ? near_coord() : int'($urandom)));
            else if (pick < 18) send(segment($urandom, $urandom, $urandom,
                                             $urandom, $urandom, $urandom));
            else send(segment(near_coord(), near_coord(), near_coord(),
                              near_coord(), near_coord(), near_coord()));
         end
      end
      start <= 1'b0;

      while (sb.hits_due.size() != 0) @(posedge clock);
      repeat (sobb_pkg::PIPE_LAT + 10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule
